// ===== src/scg_pkg.sv =====
// Shared types, constants and tables for the SVPWM compare generator.
// Used by the front end, the queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none
package scg_pkg;

  // Angle and scaling constants (65536 counts per electrical turn).
  localparam logic [15:0] SECT_WIDTH   = 16'd5461;
  localparam logic [15:0] SIXTY_DEG    = 16'd10922;
  localparam logic [15:0] THIRD_TURN   = 16'd21845;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [12:0] RATIO_GAIN   = 13'd4710;
  localparam logic [15:0] PHASE_LIMIT  = 16'd65531;
  localparam logic [1:0]  NO_PHASE     = 2'd3;
  localparam int          NUM_SECT     = 12;

  // Configuration register indexes.
  localparam logic CFG_METHOD = 1'b0;
  localparam logic CFG_STYLE  = 1'b1;

  // Modulation methods.
  localparam logic METHOD_SINE = 1'b0;

  // Stream widths.
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 56;

  // One classified item as handed from the front end to the back end.
  typedef struct packed {
    logic             space_vec;
    logic             dpwm;
    logic             inverse;
    logic [1:0]       sel_lo;
    logic [1:0]       sel_mid;
    logic [1:0]       sel_hi;
    logic [1:0]       clamped;
    logic [12:0]      ratio;
    logic [15:0]      period;
    logic [2:0][12:0] comp;
    logic [3:0][15:0] ang;
  } scg_item_t;

  // Back end sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SN_LD,
    ST_SN_C3,
    ST_SN_MS,
    ST_SN_D,
    ST_SN_DP,
    ST_SN_ST,
    ST_SV_RD,
    ST_SV_M0,
    ST_SV_M1,
    ST_SV_M2,
    ST_SV_M3,
    ST_SV_T2,
    ST_SV_CHK,
    ST_SV_DM,
    ST_SV_DI,
    ST_SV_DIV,
    ST_SV_FX,
    ST_SV_Z,
    ST_SV_ASN,
    ST_OUT
  } scg_state_e;

  // Phase that takes the zero vector, continuous style.
  function automatic logic [1:0] widest_c(input logic [3:0] sec);
    logic [1:0] r;
    unique case (sec)
      4'd0, 4'd1, 4'd10, 4'd11: r = 2'd0;
      4'd2, 4'd3, 4'd4, 4'd5:   r = 2'd1;
      default:                  r = 2'd2;
    endcase
    return r;
  endfunction

  // Phase that takes the zero vector, discontinuous style.
  function automatic logic [1:0] widest_d(input logic [3:0] sec);
    logic [1:0] r;
    unique case (sec)
      4'd1, 4'd2, 4'd7, 4'd8: r = 2'd2;
      4'd3, 4'd4, 4'd9, 4'd10: r = 2'd1;
      default:                 r = 2'd0;
    endcase
    return r;
  endfunction

  // Phase that takes the first active edge.
  function automatic logic [1:0] middle_t(input logic [3:0] sec);
    logic [1:0] r;
    unique case (sec)
      4'd0, 4'd1, 4'd6, 4'd7: r = 2'd1;
      4'd2, 4'd3, 4'd8, 4'd9: r = 2'd0;
      default:                r = 2'd2;
    endcase
    return r;
  endfunction

  // Phase that takes the second active edge, continuous style.
  function automatic logic [1:0] narrow_c(input logic [3:0] sec);
    logic [1:0] r;
    unique case (sec)
      4'd0, 4'd1, 4'd2, 4'd3: r = 2'd2;
      4'd4, 4'd5, 4'd6, 4'd7: r = 2'd0;
      default:                r = 2'd1;
    endcase
    return r;
  endfunction

  // Phase that takes the second active edge, discontinuous style.
  function automatic logic [1:0] narrow_d(input logic [3:0] sec);
    logic [1:0] r;
    unique case (sec)
      4'd0, 4'd3, 4'd6, 4'd9:  r = 2'd2;
      4'd1, 4'd4, 4'd7, 4'd10: r = 2'd0;
      default:                 r = 2'd1;
    endcase
    return r;
  endfunction

  // Quarter-wave sine table entry, round(32767*sin), evaluated at elaboration.
  function automatic logic [14:0] sine_entry(input int k, input int bits);
    real arg;
    real val;
    arg = 1.5707963267948966 * real'(k) * (2.0 ** (-bits));
    val = 32767.0 * $sin(arg);
    return 15'($rtoi(val + 0.5));
  endfunction

endpackage
`default_nettype wire

// ===== src/scg_front.sv =====
// Front end: configuration registers, input transfer and classification.
// Depends on scg_pkg; feeds scg_queue.
`timescale 1ns / 1ps
`default_nettype none
module scg_front
  import scg_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic                   cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [IN_TDATA_W-1:0]  in_data_i,
  input  wire logic                   q_full_i,
  output logic                        push_o,
  output scg_item_t                   item_o
);

  logic method_q;
  logic style_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= 1'b1;
      style_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_METHOD: method_q <= cfg_data_i;
        CFG_STYLE:  style_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  logic [15:0] phase;
  logic [15:0] sat_phase;
  logic [15:0] base;
  logic [3:0]  sec;
  logic [3:0]  sec_p1;
  logic [13:0] rem0;
  logic [13:0] rem1;
  logic [13:0] rem2;
  logic        dpwm;

  // Classify the item: sine angles or sector, angle within sector and phase order.
  always_comb begin
    phase     = in_data_i[15:0];
    sat_phase = (phase > PHASE_LIMIT) ? PHASE_LIMIT : phase;
    dpwm      = style_q;
    sec       = '0;
    for (int k = 1; k < NUM_SECT; k++) begin
      sec = sec + 4'(sat_phase >= 16'(k * SECT_WIDTH));
    end
    rem0 = 14'(sat_phase - 16'(sec * SECT_WIDTH));
    if (sec[0]) begin
      rem1 = dpwm ? 14'(SECT_WIDTH) - rem0 : 14'(SECT_WIDTH) + rem0;
    end else begin
      rem1 = rem0;
    end
    sec_p1 = sec + 4'd1;
    if (!dpwm && sec[1]) begin
      rem2 = 14'(SIXTY_DEG) - rem1;
    end else begin
      rem2 = rem1;
    end
    base = QUARTER_TURN - phase;

    item_o.space_vec = (method_q != METHOD_SINE);
    item_o.dpwm      = dpwm;
    item_o.inverse   = dpwm && sec_p1[1];
    item_o.sel_lo    = dpwm ? widest_d(sec) : widest_c(sec);
    item_o.sel_mid   = middle_t(sec);
    item_o.sel_hi    = dpwm ? narrow_d(sec) : narrow_c(sec);
    item_o.ratio     = in_data_i[28:16];
    item_o.period    = in_data_i[44:29];
    item_o.comp[0]   = in_data_i[57:45];
    item_o.comp[1]   = in_data_i[70:58];
    item_o.comp[2]   = in_data_i[83:71];
    if (method_q == METHOD_SINE) begin
      item_o.clamped = NO_PHASE;
      item_o.ang[0]  = base + {base[14:0], 1'b0};
      item_o.ang[1]  = base;
      item_o.ang[2]  = base + THIRD_TURN;
      item_o.ang[3]  = base + {THIRD_TURN[14:0], 1'b0};
    end else begin
      item_o.clamped = dpwm ? widest_d(sec) : NO_PHASE;
      item_o.ang[0]  = SIXTY_DEG - {2'b00, rem2};
      item_o.ang[1]  = {2'b00, rem2};
      item_o.ang[2]  = '0;
      item_o.ang[3]  = '0;
    end
  end

endmodule
`default_nettype wire

// ===== src/scg_queue.sv =====
// Two-entry queue between the front end and the back end.
// Depends on scg_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none
module scg_queue
  import scg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  scg_item_t      item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output scg_item_t      item_o
);

  scg_item_t  mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule
`default_nettype wire

// ===== src/scg_back.sv =====
// Back end: sequencer around a shared multiplier, sine ROM and serial divider.
// Depends on scg_pkg; takes items from scg_queue and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module scg_back
  import scg_pkg::*;
#(
  parameter int SINE_ROM_BITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_valid_i,
  input  scg_item_t                   q_item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0]      out_data_o
);

  localparam int RomDepth = (2 ** SINE_ROM_BITS) + 1;
  localparam int IdxW     = SINE_ROM_BITS + 1;

  // Quarter-wave sine table.
  logic [14:0] rom_w [RomDepth];
  for (genvar g = 0; g < RomDepth; g++) begin : g_rom
    assign rom_w[g] = sine_entry(g, SINE_ROM_BITS);
  end

  scg_state_e state_q, state_d;
  scg_item_t  item_q;
  logic [1:0] idx_q;
  logic [3:0] cnt_q;
  logic       ov_q;

  logic [14:0]        rom_q;
  logic               neg_q;
  logic signed [37:0] prod_q;
  logic signed [13:0] c3_q;
  logic [13:0]        m_q;
  logic signed [16:0] d_q;
  logic [12:0]        x1_q, x2_q;
  logic [16:0]        t1_q, t2_q, zero_q;
  logic [17:0]        tot_q, rem_q;
  logic [15:0]        quo_q;
  logic signed [20:0] cmp_q [3];
  logic [15:0]        cu_q, cv_q, cw_q;
  logic [1:0]         cl_q;

  // Control outputs of the sequencer.
  logic               rom_en;
  logic [1:0]         rom_sel;
  logic signed [18:0] mul_a, mul_b;

  logic signed [15:0] sin_s;
  logic signed [16:0] sum_s;
  logic [18:0]        trial;
  logic               trial_ge;
  logic               out_free;
  logic [16:0]        prd17;

  assign sin_s    = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
  assign sum_s    = {sin_s[15], sin_s} + {{3{c3_q[13]}}, c3_q};
  assign trial    = {rem_q, quo_q[15]};
  assign trial_ge = (trial >= {1'b0, tot_q});
  assign out_free = !ov_q || out_ready_i;
  assign prd17    = {1'b0, item_q.period};
  assign pop_o    = (state_q == ST_IDLE) && q_valid_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (q_valid_i) state_d = q_item_i.space_vec ? ST_SV_RD : ST_SN_LD;
      ST_SN_LD:  state_d = ST_SN_C3;
      ST_SN_C3:  state_d = ST_SN_MS;
      ST_SN_MS:  state_d = ST_SN_D;
      ST_SN_D:   state_d = ST_SN_DP;
      ST_SN_DP:  state_d = ST_SN_ST;
      ST_SN_ST:  state_d = (idx_q == 2'd2) ? ST_OUT : ST_SN_MS;
      ST_SV_RD:  state_d = ST_SV_M0;
      ST_SV_M0:  state_d = ST_SV_M1;
      ST_SV_M1:  state_d = ST_SV_M2;
      ST_SV_M2:  state_d = ST_SV_M3;
      ST_SV_M3:  state_d = ST_SV_T2;
      ST_SV_T2:  state_d = ST_SV_CHK;
      ST_SV_CHK: state_d = (({1'b0, t1_q} + {1'b0, t2_q}) > {2'b00, item_q.period})
                           ? ST_SV_DM : ST_SV_Z;
      ST_SV_DM:  state_d = ST_SV_DI;
      ST_SV_DI:  state_d = ST_SV_DIV;
      ST_SV_DIV: if (cnt_q == 4'd15) state_d = ST_SV_FX;
      ST_SV_FX:  state_d = ST_SV_Z;
      ST_SV_Z:   state_d = ST_SV_ASN;
      ST_SV_ASN: state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: ROM reads and multiplier operands.
  always_comb begin
    rom_en  = 1'b0;
    rom_sel = 2'd0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      ST_SN_LD: begin
        rom_en = 1'b1;
        mul_a  = {6'b0, item_q.ratio};
        mul_b  = {6'b0, RATIO_GAIN};
      end
      ST_SN_C3: begin
        rom_en  = 1'b1;
        rom_sel = 2'd1;
      end
      ST_SN_MS: begin
        rom_en  = (idx_q != 2'd2);
        rom_sel = {1'b1, idx_q[0]};
        mul_a   = {5'b0, m_q};
        mul_b   = {{2{sum_s[16]}}, sum_s};
      end
      ST_SN_DP: begin
        mul_a = {{2{d_q[16]}}, d_q};
        mul_b = {3'b0, item_q.period};
      end
      ST_SV_RD: rom_en = 1'b1;
      ST_SV_M0, ST_SV_M1: begin
        rom_en  = (state_q == ST_SV_M0);
        rom_sel = 2'd1;
        mul_a   = {4'b0, rom_q};
        mul_b   = {6'b0, item_q.ratio};
      end
      ST_SV_M2: begin
        mul_a = {6'b0, x1_q};
        mul_b = {3'b0, item_q.period};
      end
      ST_SV_M3: begin
        mul_a = {6'b0, x2_q};
        mul_b = {3'b0, item_q.period};
      end
      ST_SV_DM: begin
        mul_a = {2'b0, t1_q};
        mul_b = {3'b0, item_q.period};
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SN_C3) idx_q <= '0;
      else if (state_q == ST_SN_ST) idx_q <= idx_q + 2'd1;
      if (state_q == ST_SV_DI) cnt_q <= '0;
      else if (state_q == ST_SV_DIV) cnt_q <= cnt_q + 4'd1;
      if (state_q == ST_OUT && out_free) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // ROM read with registered data.
  logic [15:0]              rom_ang;
  logic [SINE_ROM_BITS-1:0] rom_off;
  logic [IdxW-1:0]          rom_idx;

  always_comb begin
    rom_ang = item_q.ang[rom_sel];
    rom_off = rom_ang[13:14-SINE_ROM_BITS];
    if (rom_ang[14]) begin
      rom_idx = IdxW'(2 ** SINE_ROM_BITS) - {1'b0, rom_off};
    end else begin
      rom_idx = {1'b0, rom_off};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rom_en) begin
      rom_q <= rom_w[rom_idx];
      neg_q <= rom_ang[15];
    end
  end

  logic [16:0] asn_a, asn_b, asn_z;

  always_comb begin
    asn_a = zero_q + t1_q;
    asn_b = asn_a + t2_q;
    asn_z = zero_q;
    if (item_q.inverse) begin
      asn_z = prd17 - zero_q;
      asn_a = prd17 - asn_a;
      asn_b = prd17 - asn_b;
    end
  end

  // Final correction and clamp to 0..period.
  logic signed [21:0] fin [3];
  logic [15:0]        clip [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin[i] = {cmp_q[i][20], cmp_q[i]};
      if (item_q.ratio != '0 && item_q.clamped != 2'(i)) begin
        fin[i] = fin[i] + {{9{item_q.comp[i][12]}}, item_q.comp[i]};
      end
      if (fin[i] > $signed({6'b0, item_q.period})) clip[i] = item_q.period;
      else if (fin[i] < 0) clip[i] = '0;
      else clip[i] = fin[i][15:0];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (pop_o) item_q <= q_item_i;
    unique case (state_q)
      ST_SN_C3: begin
        c3_q <= sin_s[15:2];
        m_q  <= prod_q[25:12];
      end
      ST_SN_D:  d_q <= 17'sd4096 - prod_q[31:15];
      ST_SN_ST: cmp_q[idx_q] <= prod_q[33:13];
      ST_SV_M1: x1_q <= prod_q[27:15];
      ST_SV_M2: x2_q <= prod_q[27:15];
      ST_SV_M3: t1_q <= prod_q[28:12];
      ST_SV_T2: t2_q <= prod_q[28:12];
      ST_SV_DM: tot_q <= {1'b0, t1_q} + {1'b0, t2_q};
      ST_SV_DI: begin
        rem_q <= {1'b0, prod_q[32:16]};
        quo_q <= prod_q[15:0];
      end
      ST_SV_DIV: begin
        rem_q <= trial_ge ? 18'(trial - {1'b0, tot_q}) : trial[17:0];
        quo_q <= {quo_q[14:0], trial_ge};
      end
      ST_SV_FX: begin
        t1_q <= {1'b0, quo_q};
        t2_q <= prd17 - {1'b0, quo_q};
      end
      ST_SV_Z: begin
        zero_q <= item_q.dpwm ? '0 : ((prd17 - t1_q - t2_q) >> 1);
      end
      ST_SV_ASN: begin
        cmp_q[item_q.sel_lo]  <= {4'b0, asn_z};
        cmp_q[item_q.sel_mid] <= {4'b0, asn_a};
        cmp_q[item_q.sel_hi]  <= {4'b0, asn_b};
      end
      ST_OUT: begin
        if (out_free) begin
          cu_q <= clip[0];
          cv_q <= clip[1];
          cw_q <= clip[2];
          cl_q <= item_q.clamped;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {6'b0, cl_q, cw_q, cv_q, cu_q};

endmodule
`default_nettype wire

// ===== src/svpwm_compare_generator_core.sv =====
// Top level of the SVPWM compare generator: front end, queue, back end.
// Depends on scg_pkg, scg_front, scg_queue and scg_back.
//
// Once per carrier period this block turns an output angle, a Q12 modulation
// ratio, the carrier period and three dead-band corrections into three
// compare values clamped to 0..period plus the index of the rail-clamped
// phase. One input transfer yields one output transfer. The back end
// works on one item at a time, sharing one multiplier and one sine ROM
// port; a space-vector item needs a one-bit-per-cycle division when
// overmodulation rescales T1 and T2. A two-entry queue lets new items
// arrive while the back end works.
`timescale 1ns / 1ps
`default_nettype none
module svpwm_compare_generator_core
  import scg_pkg::*;
#(
  parameter int SINE_ROM_BITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic                   cfg_data_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // out_phase, mod_ratio, carrier_period, dead_comp_u, dead_comp_v, dead_comp_w
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // compare_u, compare_v, compare_w, clamped_phase
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  scg_item_t front_item;
  scg_item_t queue_item;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_valid;

  // Input transfer and classification.
  scg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (front_item)
  );

  // Decoupling queue.
  scg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (queue_item)
  );

  // Compare computation and output register.
  scg_back #(
    .SINE_ROM_BITS (SINE_ROM_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (queue_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire
